@@ sv/luminance_retarget_srgb_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef LUMINANCE_RETARGET_SRGB_DEFINES_SVH
`define LUMINANCE_RETARGET_SRGB_DEFINES_SVH
`ifndef SYNTHESIS
`define LRS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lrs assertion failed");
`define LRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrs assertion failed");
`else
`define LRS_ASSERT(label, clk, rst, prop)
`define LRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/lrs_pkg.sv @@
package lrs_pkg;

  localparam int LINEAR_FRAC_BITS  = 16;
  localparam int ENCODE_INDEX_BITS = 12;
  localparam int CODE_W   = 8;
  localparam int TARGET_W = 17;
  localparam int K_W      = 16;
  localparam int THR_W    = 24;

  typedef enum logic [1:0] {
    CH_R = 2'd0,
    CH_G = 2'd1,
    CH_B = 2'd2
  } ch_t;

  // Rec.709 weights in Q16, summing to exactly 1.0
  localparam logic [K_W-1:0] KR = 16'd13933;
  localparam logic [K_W-1:0] KG = 16'd46871;
  localparam logic [K_W-1:0] KB = 16'd4732;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  function automatic logic [K_W-1:0] luma_k(ch_t ch);
    case (ch)
      CH_R:    return KR;
      CH_G:    return KG;
      default: return KB;
    endcase
  endfunction

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // round(2^24 * u^2.4) for u in Q30, via a bisected fifth root of u^2
  function automatic longint unsigned pow24_q30(longint unsigned u_in);
    longint unsigned u, u2, lo, hi, mid, p;
    u = (u_in > Q30_ONE) ? Q30_ONE : u_in;
    u2 = mul_q30(u, u);
    lo = 0;
    hi = Q30_ONE;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      p = mul_q30(mid, mid);
      p = mul_q30(p, mid);
      p = mul_q30(p, mid);
      p = mul_q30(p, mid);
      if (p <= u2) lo = mid;
      else hi = mid - 64'd1;
    end
    return (mul_q30(u2, lo) + 64'd32) >> 6;
  endfunction

  function automatic longint unsigned decode24(int c);
    longint unsigned cu;
    cu = longint'(c);
    if (cu <= 64'd10) return ((cu * 64'd100 << 24) + 64'd164730) / 64'd329460;
    return pow24_q30(((cu * 64'd1000 + 64'd14025) << 30) / 64'd269025);
  endfunction

  function automatic longint unsigned thresh24(int c);
    longint unsigned cu;
    cu = longint'(c);
    if (cu <= 64'd9)
      return (((64'd2 * cu + 64'd1) * 64'd100 << 24) + 64'd329460) / 64'd658920;
    return pow24_q30((((64'd2 * cu + 64'd1) * 64'd100 + 64'd2805) << 30) / 64'd53805);
  endfunction

  // linear value at f fraction bits, rounded, floored at one LSB
  function automatic longint unsigned decode_lin(int c, int f);
    longint unsigned v, r;
    int s;
    v = decode24(c);
    s = THR_W - f;
    if (s == 0) r = v;
    else r = (v + (64'd1 << (s - 1))) >> s;
    return (r < 64'd1) ? 64'd1 : r;
  endfunction

endpackage

@@ sv/lrs_if.sv @@
interface lrs_in_if;
  logic valid;
  logic ready;
  logic [lrs_pkg::CODE_W-1:0]   red_in;
  logic [lrs_pkg::CODE_W-1:0]   green_in;
  logic [lrs_pkg::CODE_W-1:0]   blue_in;
  logic [lrs_pkg::TARGET_W-1:0] target_luma;
  modport source (output valid, red_in, green_in, blue_in, target_luma, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, target_luma, output ready);
endinterface

interface lrs_out_if;
  logic valid;
  logic ready;
  logic [lrs_pkg::CODE_W-1:0] red_out;
  logic [lrs_pkg::CODE_W-1:0] green_out;
  logic [lrs_pkg::CODE_W-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

@@ sv/lrs_decode.sv @@
module lrs_decode #(
  parameter int F = lrs_pkg::LINEAR_FRAC_BITS,
  localparam int CW = F + 1,
  localparam int TW = lrs_pkg::TARGET_W,
  localparam int KW = lrs_pkg::K_W,
  localparam int YW = F + KW + 1,
  localparam int PW = CW + TW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [lrs_pkg::CODE_W-1:0] red,
  input  logic [lrs_pkg::CODE_W-1:0] green,
  input  logic [lrs_pkg::CODE_W-1:0] blue,
  input  logic [TW-1:0]              target,
  output logic                       out_valid,
  output logic [PW-1:0]              prod [3],
  output logic [YW-1:0]              luma,
  output logic [TW-1:0]              tgt
);

  logic [CW-1:0]              dec_tbl [256];
  logic [lrs_pkg::CODE_W-1:0] code [3];
  logic [CW-1:0]              lin [3];
  logic [TW-1:0]              t_a;
  logic                       v_a;

  for (genvar g = 0; g < 256; g++) begin : g_tbl
    localparam logic [CW-1:0] Val = CW'(lrs_pkg::decode_lin(g, F));
    assign dec_tbl[g] = Val;
  end

  assign code[0] = red;
  assign code[1] = green;
  assign code[2] = blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a       <= in_valid;
      out_valid <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lin[j]  <= dec_tbl[code[j]];
        prod[j] <= PW'(lin[j]) * PW'(t_a);
      end
      t_a  <= target;
      tgt  <= t_a;
      luma <= YW'(lrs_pkg::KR) * YW'(lin[0]) + YW'(lrs_pkg::KG) * YW'(lin[1])
            + YW'(lrs_pkg::KB) * YW'(lin[2]);
    end
  end

endmodule

@@ sv/lrs_div.sv @@
// floor(dividend * 2^SHIFT / divisor), one quotient bit per stage.
// The quotient must fit QW bits; a zero divisor gives junk.
module lrs_div #(
  parameter int AW    = 34,
  parameter int DW    = 33,
  parameter int QW    = 21,
  parameter int SHIFT = 16,
  parameter int LANES = 1,
  parameter int SW    = 1,
  localparam int NW   = AW + SHIFT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [AW-1:0] dividend [LANES],
  input  logic [DW-1:0] divisor [LANES],
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot [LANES],
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem  [QW+1][LANES];
  logic [QW-1:0] nlo  [QW+1][LANES];
  logic [DW-1:0] dv   [QW+1][LANES];
  logic [QW-1:0] q    [QW+1][LANES];
  logic [SW-1:0] sb   [QW+1];
  logic          vld  [QW+1];
  logic [NW-1:0] nfull [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign nfull[l]  = {dividend[l], {SHIFT{1'b0}}};
    assign rem[0][l] = DW'(nfull[l] >> QW);
    assign nlo[0][l] = nfull[l][QW-1:0];
    assign dv[0][l]  = divisor[l];
    assign q[0][l]   = '0;
  end
  assign sb[0]  = side_in;
  assign vld[0] = in_valid;

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [DW:0] trial [LANES];
    logic        take  [LANES];

    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else if (en) vld[s] <= vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) sb[s] <= sb[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign trial[l] = {rem[s-1][l], nlo[s-1][l][QW-s]};
      assign take[l]  = trial[l] >= {1'b0, dv[s-1][l]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[s][l] <= take[l] ? DW'(trial[l] - {1'b0, dv[s-1][l]}) : trial[l][DW-1:0];
          nlo[s][l] <= nlo[s-1][l];
          dv[s][l]  <= dv[s-1][l];
          q[s][l]   <= {q[s-1][l][QW-2:0], take[l]};
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot[l] = q[QW][l];
  end
  assign side_out  = sb[QW];
  assign out_valid = vld[QW];

endmodule

@@ sv/lrs_encode.sv @@
// Linear to sRGB code: binary search over the 255 decision thresholds,
// four steps in each of two stages.
module lrs_encode #(
  parameter int F = lrs_pkg::LINEAR_FRAC_BITS,
  parameter int E = lrs_pkg::ENCODE_INDEX_BITS,
  localparam int CW = F + 1,
  localparam int TH = lrs_pkg::THR_W,
  localparam int BW = lrs_pkg::CODE_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [CW-1:0] lin [3],
  output logic          out_valid,
  output logic [BW-1:0] code [3]
);

  logic [TH-1:0] thr_tbl [255];
  logic [E:0]    sh [3];
  logic [E-1:0]  idx [3];
  logic [TH-1:0] probe [3];
  logic [TH-1:0] probe_r [3];
  logic [BW-1:0] hi_code [3];
  logic [BW-1:0] hi_r [3];
  logic [BW-1:0] lo_code [3];
  logic          v_s;

  for (genvar g = 0; g < 255; g++) begin : g_tbl
    localparam logic [TH-1:0] Val = TH'(lrs_pkg::thresh24(g));
    assign thr_tbl[g] = Val;
  end

  for (genvar l = 0; l < 3; l++) begin : g_idx
    if (F >= E) begin : g_down
      assign sh[l] = (E+1)'(lin[l] >> (F - E));
    end else begin : g_up
      assign sh[l] = {lin[l], {(E - F){1'b0}}};
    end
    // full scale lands one past the last index
    assign idx[l]   = sh[l][E] ? {E{1'b1}} : sh[l][E-1:0];
    assign probe[l] = {idx[l], {(TH - E){1'b0}}};
  end

  always_comb begin
    logic [BW-1:0] cand;
    cand = '0;
    for (int l = 0; l < 3; l++) begin
      hi_code[l] = '0;
      for (int b = BW - 1; b >= BW / 2; b--) begin
        cand = hi_code[l] | (BW'(1) << b);
        if (thr_tbl[cand - BW'(1)] <= probe[l]) hi_code[l] = cand;
      end
    end
  end

  always_comb begin
    logic [BW-1:0] cand;
    cand = '0;
    for (int l = 0; l < 3; l++) begin
      lo_code[l] = hi_r[l];
      for (int b = BW / 2 - 1; b >= 0; b--) begin
        cand = lo_code[l] | (BW'(1) << b);
        if (thr_tbl[cand - BW'(1)] <= probe_r[l]) lo_code[l] = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_s       <= in_valid;
      out_valid <= v_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        probe_r[l] <= probe[l];
        hi_r[l]    <= hi_code[l];
        code[l]    <= lo_code[l];
      end
    end
  end

endmodule

@@ sv/luminance_retarget_srgb.sv @@
// Luminance retargeting of sRGB pixels.
// pix_in carries one pixel (red_in, green_in, blue_in) and the wanted
// luminance target_luma (Q16, 65536 = 1.0); pix_out returns the adjusted
// codes. A request moves when valid and ready are both high.
// One pixel per clock sustained while the sink keeps ready high. In order
// the pipeline holds decode and products, three bit-serial dividers of
// LINEAR_FRAC_BITS+5 stages each (scale, rescale after the first clip,
// rescale after the second), clip and select logic, the encoder search
// and the output register.
// The whole pipeline advances on one enable; a skid register behind the
// output register takes one more result while the sink stalls, after which
// ready drops until the skid drains. Nothing is lost or repeated on a stall.
// Reset (rst, synchronous) empties the pipeline and both output registers;
// there is no other state and no configuration.
`include "luminance_retarget_srgb_defines.svh"

module luminance_retarget_srgb #(
  parameter int LINEAR_FRAC_BITS  = lrs_pkg::LINEAR_FRAC_BITS,
  parameter int ENCODE_INDEX_BITS = lrs_pkg::ENCODE_INDEX_BITS
) (
  input logic        clk,
  input logic        rst,
  lrs_in_if.sink     pix_in,
  lrs_out_if.source  pix_out
);

  localparam int F   = LINEAR_FRAC_BITS;
  localparam int CW  = F + 1;
  localparam int TW  = lrs_pkg::TARGET_W;
  localparam int KW  = lrs_pkg::K_W;
  localparam int BW  = lrs_pkg::CODE_W;
  localparam int YW  = F + KW + 1;
  localparam int A1W = CW + TW;
  localparam int QW  = F + 5;
  localparam int A2W = QW + TW;
  localparam int RW  = KW + QW + 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;
  localparam logic [CW-1:0] ONE_C = CW'(1) << F;

  typedef struct packed {
    logic                   over;
    lrs_pkg::ch_t           i;
    logic [TW-1:0]          num1;
    logic [2:0][QW-1:0]     c1;
  } base_t;

  typedef struct packed {
    base_t         b;
    logic [QW-1:0] cp;
    logic [QW-1:0] cq;
    logic [KW-1:0] kp;
    logic [KW-1:0] kq;
  } clip1_t;

  typedef struct packed {
    base_t b;
    logic  z2;
  } side2_t;

  typedef struct packed {
    base_t         b;
    logic          over2;
    lrs_pkg::ch_t  i2;
    lrs_pkg::ch_t  kk;
    logic          cknz;
    logic [QW-1:0] c2p;
    logic [QW-1:0] c2q;
  } side3_t;

  localparam int S2W = $bits(side2_t);
  localparam int S3W = $bits(side3_t);

  function automatic lrs_pkg::ch_t lo_other(lrs_pkg::ch_t ch);
    case (ch)
      lrs_pkg::CH_R: return lrs_pkg::CH_G;
      default:       return lrs_pkg::CH_R;
    endcase
  endfunction

  function automatic lrs_pkg::ch_t hi_other(lrs_pkg::ch_t ch);
    case (ch)
      lrs_pkg::CH_B: return lrs_pkg::CH_G;
      default:       return lrs_pkg::CH_B;
    endcase
  endfunction

  logic en;
  logic main_v, skid_v;
  logic [BW-1:0] main_code [3];
  logic [BW-1:0] skid_code [3];

  assign en = !skid_v;
  assign pix_in.ready = en;

  // decode and products
  logic           dec_v;
  logic [A1W-1:0] prod [3];
  logic [YW-1:0]  luma;
  logic [TW-1:0]  tgt;

  lrs_decode #(.F(F)) u_decode (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pix_in.valid),
    .red      (pix_in.red_in),
    .green    (pix_in.green_in),
    .blue     (pix_in.blue_in),
    .target   (pix_in.target_luma),
    .out_valid(dec_v),
    .prod     (prod),
    .luma     (luma),
    .tgt      (tgt)
  );

  // common scale
  logic [YW-1:0] d1_den [3];
  logic          d1_v;
  logic [QW-1:0] q1 [3];
  logic [TW-1:0] t1;

  assign d1_den[0] = luma;
  assign d1_den[1] = luma;
  assign d1_den[2] = luma;

  lrs_div #(
    .AW(A1W), .DW(YW), .QW(QW), .SHIFT(F), .LANES(3), .SW(TW)
  ) u_div_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (dec_v),
    .dividend (prod),
    .divisor  (d1_den),
    .side_in  (tgt),
    .out_valid(d1_v),
    .quot     (q1),
    .side_out (t1)
  );

  // first clip: pick the largest, set up the rescale of the other two
  clip1_t c1_next, c1_r;
  logic   c1_v;

  always_comb begin
    lrs_pkg::ch_t  im, lo, hi;
    logic [QW-1:0] best;
    logic [KW-1:0] ki;
    im = lrs_pkg::CH_R;
    best = q1[0];
    if (q1[1] > best) begin
      im = lrs_pkg::CH_G;
      best = q1[1];
    end
    if (q1[2] > best) begin
      im = lrs_pkg::CH_B;
      best = q1[2];
    end
    lo = lo_other(im);
    hi = hi_other(im);
    ki = lrs_pkg::luma_k(im);
    c1_next.b.over  = best > ONE_Q;
    c1_next.b.i     = im;
    c1_next.b.num1  = (t1 > TW'(ki)) ? t1 - TW'(ki) : '0;
    c1_next.b.c1[0] = q1[0];
    c1_next.b.c1[1] = q1[1];
    c1_next.b.c1[2] = q1[2];
    c1_next.cp      = c1_next.b.c1[lo];
    c1_next.cq      = c1_next.b.c1[hi];
    c1_next.kp      = lrs_pkg::luma_k(lo);
    c1_next.kq      = lrs_pkg::luma_k(hi);
  end

  // rescale products
  side2_t         c2_side;
  logic [RW-1:0]  c2_rest;
  logic [A2W-1:0] c2_a [2];
  logic [RW-1:0]  c2_den [2];
  logic           c2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
    end else if (en) begin
      c1_v <= d1_v;
      c2_v <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r       <= c1_next;
      c2_side.b  <= c1_r.b;
      c2_side.z2 <= (c1_r.cp == '0) && (c1_r.cq == '0);
      c2_rest    <= RW'(c1_r.kp) * RW'(c1_r.cp) + RW'(c1_r.kq) * RW'(c1_r.cq);
      c2_a[0]    <= A2W'(c1_r.cp) * A2W'(c1_r.b.num1);
      c2_a[1]    <= A2W'(c1_r.cq) * A2W'(c1_r.b.num1);
    end
  end

  assign c2_den[0] = c2_rest;
  assign c2_den[1] = c2_rest;

  logic           d2_v;
  logic [QW-1:0]  q2 [2];
  logic [S2W-1:0] d2_side_vec;
  side2_t         d2_side;

  lrs_div #(
    .AW(A2W), .DW(RW), .QW(QW), .SHIFT(F), .LANES(2), .SW(S2W)
  ) u_div_rescale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c2_v),
    .dividend (c2_a),
    .divisor  (c2_den),
    .side_in  (c2_side),
    .out_valid(d2_v),
    .quot     (q2),
    .side_out (d2_side_vec)
  );

  assign d2_side = side2_t'(d2_side_vec);

  // second clip; a zero weighted sum saturates the lower other channel and leaves the higher to the last divider
  side3_t        s3_next, s3_r;
  logic [TW-1:0] num2_next, num2_r [1];
  logic [KW-1:0] k3_r [1];
  logic [KW-1:0] k3_next;
  logic          s3_v;

  always_comb begin
    lrs_pkg::ch_t  lo, hi;
    logic          sat, pick_hi;
    logic [KW-1:0] k2;
    lo = lo_other(d2_side.b.i);
    hi = hi_other(d2_side.b.i);
    sat = d2_side.z2;
    pick_hi = !sat && (q2[1] > q2[0]);
    s3_next.b     = d2_side.b;
    s3_next.c2p   = q2[0];
    s3_next.c2q   = q2[1];
    s3_next.i2    = pick_hi ? hi : lo;
    s3_next.kk    = pick_hi ? lo : hi;
    s3_next.over2 = sat || ((pick_hi ? q2[1] : q2[0]) > ONE_Q);
    s3_next.cknz  = sat || ((pick_hi ? q2[0] : q2[1]) != '0);
    k2 = lrs_pkg::luma_k(s3_next.i2);
    num2_next = (d2_side.b.num1 > TW'(k2)) ? d2_side.b.num1 - TW'(k2) : '0;
    k3_next = lrs_pkg::luma_k(s3_next.kk);
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= d2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r      <= s3_next;
      num2_r[0] <= num2_next;
      k3_r[0]   <= k3_next;
    end
  end

  // last channel: c*num2/(k*c) reduces to num2/k
  logic           d3_v;
  logic [QW-1:0]  q3 [1];
  logic [S3W-1:0] d3_side_vec;
  side3_t         d3_side;

  lrs_div #(
    .AW(TW), .DW(KW), .QW(QW), .SHIFT(F), .LANES(1), .SW(S3W)
  ) u_div_last (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_v),
    .dividend (num2_r),
    .divisor  (k3_r),
    .side_in  (s3_r),
    .out_valid(d3_v),
    .quot     (q3),
    .side_out (d3_side_vec)
  );

  assign d3_side = side3_t'(d3_side_vec);

  logic [CW-1:0] lin_next [3];
  logic [CW-1:0] lin_r [3];
  logic          fin_v;

  always_comb begin
    lrs_pkg::ch_t lo, hi;
    lo = lo_other(d3_side.b.i);
    hi = hi_other(d3_side.b.i);
    for (int j = 0; j < 3; j++) lin_next[j] = CW'(d3_side.b.c1[j]);
    if (d3_side.b.over) begin
      lin_next[d3_side.b.i] = ONE_C;
      if (!d3_side.over2) begin
        lin_next[lo] = CW'(d3_side.c2p);
        lin_next[hi] = CW'(d3_side.c2q);
      end else begin
        lin_next[d3_side.i2] = ONE_C;
        if (!d3_side.cknz || q3[0] > ONE_Q) lin_next[d3_side.kk] = ONE_C;
        else lin_next[d3_side.kk] = CW'(q3[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fin_v <= 1'b0;
    else if (en) fin_v <= d3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) lin_r[j] <= lin_next[j];
    end
  end

  logic          enc_v;
  logic [BW-1:0] enc_code [3];

  lrs_encode #(.F(F), .E(ENCODE_INDEX_BITS)) u_encode (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (fin_v),
    .lin      (lin_r),
    .out_valid(enc_v),
    .code     (enc_code)
  );

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (!main_v || pix_out.ready) begin
      main_v <= skid_v || enc_v;
      skid_v <= 1'b0;
    end else if (enc_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v || pix_out.ready) begin
      for (int j = 0; j < 3; j++) main_code[j] <= skid_v ? skid_code[j] : enc_code[j];
    end else if (enc_v && en) begin
      for (int j = 0; j < 3; j++) skid_code[j] <= enc_code[j];
    end
  end

  assign pix_out.valid     = main_v;
  assign pix_out.red_out   = main_code[0];
  assign pix_out.green_out = main_code[1];
  assign pix_out.blue_out  = main_code[2];

  `LRS_ASSERT(a_skid_needs_main, clk, rst, skid_v |-> main_v)
  `LRS_ASSERT_NEXT(a_skid_only_on_stall, clk, rst, !(main_v && !pix_out.ready), !skid_v)
  `LRS_ASSERT(a_lin_in_range, clk, rst, fin_v |-> (lin_r[0] <= ONE_C && lin_r[1] <= ONE_C && lin_r[2] <= ONE_C))

endmodule
